@@ rtl/core/ffa_pkg.sv @@
`default_nettype none

package ffa_pkg;

  // Fixed widths of the item fields at the block boundary.
  localparam int unsigned ActionW   = 2;
  localparam int unsigned ReqWordsW = 10;
  localparam int unsigned OwnerInW  = 8;
  localparam int unsigned AddrW     = 10;

  // Action codes carried by an input item.
  localparam logic [ActionW-1:0] ActAlloc   = 2'd0;
  localparam logic [ActionW-1:0] ActFree    = 2'd1;
  localparam logic [ActionW-1:0] ActFreeAll = 2'd2;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] address;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/ffa_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module ffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/ffa_ctrl.sv @@
`default_nettype none

// Sequencer that walks the header chain held in the header RAM.
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int unsigned ARENA_WORDS = 1024,
  parameter int unsigned OWNER_BITS  = 8,
  localparam int unsigned IdxW   = $clog2(ARENA_WORDS),
  localparam int unsigned EntryW = IdxW + 1 + OWNER_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ActionW-1:0]   action_i,
  input  wire logic [ReqWordsW-1:0] request_words_i,
  input  wire logic [OwnerInW-1:0]  owner_i,
  input  wire logic [AddrW-1:0]     block_address_i,
  output logic                      ram_we_o,
  output logic      [IdxW-1:0]      ram_waddr_o,
  output logic      [EntryW-1:0]    ram_wdata_o,
  output logic      [IdxW-1:0]      ram_raddr_o,
  input  wire logic [EntryW-1:0]    ram_rdata_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output result_t                   res_o
);

  localparam int unsigned NwW    = ReqWordsW + 1;
  localparam int unsigned SumW   = ((IdxW > ReqWordsW) ? IdxW : ReqWordsW) + 1;
  localparam int unsigned WalkLimit = 4 * ARENA_WORDS + 8;
  localparam int unsigned StepW  = $clog2(4 * ARENA_WORDS + 10);
  localparam int unsigned NextLo = OWNER_BITS + 1;
  localparam int unsigned BusyB  = OWNER_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ARENA_WORDS - 1);

  localparam logic [3:0] SInit0  = 4'd0;
  localparam logic [3:0] SInit1  = 4'd1;
  localparam logic [3:0] SIdle   = 4'd2;
  localparam logic [3:0] SAllocP = 4'd3;
  localparam logic [3:0] SAllocQ = 4'd4;
  localparam logic [3:0] SSplit  = 4'd5;
  localparam logic [3:0] STake   = 4'd6;
  localparam logic [3:0] SFree   = 4'd7;
  localparam logic [3:0] SFreeAll = 4'd8;
  localparam logic [3:0] SEmit   = 4'd9;

  function automatic logic [EntryW-1:0] pack_hdr(input logic [IdxW-1:0] nx,
                                                 input logic bz,
                                                 input logic [OWNER_BITS-1:0] ow);
    return {nx, bz, ow};
  endfunction

  logic [3:0]            state_q, state_d;
  logic [IdxW-1:0]       p_q, p_d;
  logic [IdxW-1:0]       q_q, q_d;
  logic [IdxW-1:0]       nxt_q, nxt_d;
  logic [OWNER_BITS-1:0] hown_q, hown_d;
  logic [OWNER_BITS-1:0] tag_q, tag_d;
  logic [NwW-1:0]        nw_q, nw_d;
  logic [StepW-1:0]      steps_q, steps_d;
  logic                  pass_q, pass_d;
  result_t               res_q, res_d;

  logic [IdxW-1:0]       rd_next;
  logic                  rd_busy;
  logic [OWNER_BITS-1:0] rd_owner;
  logic [StepW-1:0]      steps_inc;
  logic                  over_limit;
  logic [IdxW-1:0]       adv_next;
  logic                  adv_wrap;
  logic                  adv_fail;
  logic [SumW-1:0]       end_need;
  logic                  fits;
  logic                  free_ok;
  logic [IdxW-1:0]       free_hdr;

  assign rd_next  = ram_rdata_i[NextLo +: IdxW];
  assign rd_busy  = ram_rdata_i[BusyB];
  assign rd_owner = ram_rdata_i[OWNER_BITS-1:0];

  assign steps_inc  = steps_q + StepW'(1);
  assign over_limit = 32'(steps_inc) > WalkLimit;

  // Advancing to the next header: from the fresh read in SAllocP, or from the
  // merged link held in nxt_q after the merge loop.
  assign adv_next = (state_q == SAllocP) ? rd_next : nxt_q;
  assign adv_wrap = adv_next <= p_q;
  assign adv_fail = over_limit || (adv_wrap && ((adv_next != '0) || pass_q));

  assign end_need = SumW'(p_q) + SumW'(nw_q);
  assign fits     = SumW'(q_q) >= end_need;

  assign free_ok  = (block_address_i != '0) && (32'(block_address_i) <= ARENA_WORDS);
  assign free_hdr = IdxW'(block_address_i - AddrW'(1));

  assign in_ready_o  = (state_q == SIdle);
  assign res_valid_o = (state_q == SEmit);
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    q_d     = q_q;
    nxt_d   = nxt_q;
    hown_d  = hown_q;
    tag_d   = tag_q;
    nw_d    = nw_q;
    steps_d = steps_q;
    pass_d  = pass_q;
    res_d   = res_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = p_q;
    ram_wdata_o = pack_hdr(nxt_q, 1'b0, hown_q);
    ram_raddr_o = p_q;

    unique case (state_q)
      SInit0: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        ram_wdata_o = pack_hdr(LastIdx, 1'b0, '0);
        state_d     = SInit1;
      end
      SInit1: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = LastIdx;
        ram_wdata_o = pack_hdr('0, 1'b1, '0);
        state_d     = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          tag_d = OWNER_BITS'(owner_i);
          unique case (action_i)
            ActAlloc: begin
              p_d         = '0;
              steps_d     = '0;
              pass_d      = 1'b0;
              nw_d        = NwW'(request_words_i) + NwW'(1);
              ram_raddr_o = '0;
              state_d     = SAllocP;
            end
            ActFree: begin
              if (free_ok) begin
                p_d         = free_hdr;
                ram_raddr_o = free_hdr;
                state_d     = SFree;
              end else begin
                res_d   = '{ok: 1'b1, address: '0};
                state_d = SEmit;
              end
            end
            ActFreeAll: begin
              p_d         = '0;
              ram_raddr_o = '0;
              state_d     = SFreeAll;
            end
            default: begin
              res_d   = '{ok: 1'b0, address: '0};
              state_d = SEmit;
            end
          endcase
        end
      end
      SAllocP, SAllocQ: begin
        if ((state_q == SAllocP) && !rd_busy) begin
          // Idle block: start merging with the headers that follow it.
          nxt_d       = rd_next;
          hown_d      = rd_owner;
          q_d         = rd_next;
          ram_raddr_o = rd_next;
          state_d     = SAllocQ;
        end else if ((state_q == SAllocQ) && !rd_busy) begin
          if (over_limit) begin
            ram_we_o = 1'b1;
            res_d    = '{ok: 1'b0, address: '0};
            state_d  = SEmit;
          end else begin
            steps_d     = steps_inc;
            nxt_d       = rd_next;
            q_d         = rd_next;
            ram_raddr_o = rd_next;
          end
        end else if ((state_q == SAllocQ) && fits) begin
          state_d = SSplit;
        end else begin
          // Write back the merged link, then step along the chain.
          ram_we_o = (state_q == SAllocQ);
          if (adv_fail) begin
            res_d   = '{ok: 1'b0, address: '0};
            state_d = SEmit;
          end else begin
            steps_d     = steps_inc;
            pass_d      = pass_q | adv_wrap;
            p_d         = adv_next;
            ram_raddr_o = adv_next;
            state_d     = SAllocP;
          end
        end
      end
      SSplit: begin
        ram_waddr_o = IdxW'(end_need);
        ram_wdata_o = pack_hdr(nxt_q, 1'b0, '0);
        ram_we_o    = SumW'(q_q) > end_need;
        state_d     = STake;
      end
      STake: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = pack_hdr(IdxW'(end_need), 1'b1, tag_q);
        res_d       = '{ok: 1'b1, address: AddrW'(p_q + IdxW'(1))};
        state_d     = SEmit;
      end
      SFree: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = pack_hdr(rd_next, 1'b0, '0);
        res_d       = '{ok: 1'b1, address: '0};
        state_d     = SEmit;
      end
      SFreeAll: begin
        ram_wdata_o = pack_hdr(rd_next, 1'b0, '0);
        ram_we_o    = (rd_owner == tag_q) && (p_q != LastIdx);
        if (rd_next <= p_q) begin
          res_d   = '{ok: 1'b1, address: '0};
          state_d = SEmit;
        end else begin
          p_d         = rd_next;
          ram_raddr_o = rd_next;
        end
      end
      SEmit: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    q_q     <= q_d;
    nxt_q   <= nxt_d;
    hown_q  <= hown_d;
    tag_q   <= tag_d;
    nw_q    <= nw_d;
    steps_q <= steps_d;
    pass_q  <= pass_d;
    res_q   <= res_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/first_fit_arena_allocator_core.sv @@
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------------------
// in       | input     | in_valid_i / in_ready_o   | action_i, request_words_i, owner_i,
//          |           |                           | block_address_i
// out      | output    | out_valid_o / out_ready_i | ok_o, address_o
//
// One item is worked on at a time; each item gives exactly one result item.
// Free-all walks every header on the chain, and allocate walks the chain block by
// block, merging idle neighbours, then splits and takes the block it found: every
// step is one access to the single-port-read header RAM.
// After reset the block writes the base and end headers, in SInit0 and SInit1,
// and only then raises in_ready_o. A result waiting in the output register does
// not stop the next item from being accepted and worked on.
module first_fit_arena_allocator_core
  import ffa_pkg::*;
#(
  parameter int unsigned ARENA_WORDS = 1024,
  parameter int unsigned OWNER_BITS  = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ActionW-1:0]   action_i,
  input  wire logic [ReqWordsW-1:0] request_words_i,
  input  wire logic [OwnerInW-1:0]  owner_i,
  input  wire logic [AddrW-1:0]     block_address_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      ok_o,
  output logic      [AddrW-1:0]     address_o
);

  localparam int unsigned IdxW   = $clog2(ARENA_WORDS);
  localparam int unsigned EntryW = IdxW + 1 + OWNER_BITS;

  // Header RAM ports. Each entry holds {next header, busy, owner}.
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  // Result hand-over from the sequencer to the output register.
  logic    res_valid;
  logic    res_ready;
  result_t res;

  logic             out_valid_q, out_valid_d;
  logic             ok_q, ok_d;
  logic [AddrW-1:0] address_q, address_d;

  ffa_ram #(
    .Width (EntryW),
    .Depth (ARENA_WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffa_ctrl #(
    .ARENA_WORDS (ARENA_WORDS),
    .OWNER_BITS  (OWNER_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .request_words_i (request_words_i),
    .owner_i         (owner_i),
    .block_address_i (block_address_i),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // The output register takes a new result whenever it is empty or is being
  // emptied in the same cycle, so a stalled consumer only holds the sequencer
  // once a second result is ready.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    address_d   = address_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      ok_d        = res.ok;
      address_d   = res.address;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    address_q <= address_d;
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign address_o   = address_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffa_pkg::*;

  // The arena is used at its default size, so the end sentinel sits at the top word.
  localparam int ArenaWords = 1024;
  localparam int LastIdx    = ArenaWords - 1;
  localparam int WalkLimit  = 4 * ArenaWords + 8;
  localparam int RandomItems = 900;

  // The package names the three real actions only; the fourth code is undefined.
  localparam logic [ActionW-1:0] ActUnknown = 2'd3;

  // The scoreboard keeps a private copy of the header chain. Every accepted item is
  // run through it at once, so that the stimulus can pick live blocks from it, and
  // the result that the item should produce is queued for comparison.
  class arena_scoreboard;
    logic [AddrW-1:0]    link   [ArenaWords];
    bit                  in_use [ArenaWords];
    logic [OwnerInW-1:0] tag_of [ArenaWords];
    bit                  written[ArenaWords];
    int                  written_list[$];
    result_t             pending_results[$];
    int                  error_count;
    int                  mismatch_count;

    function new();
      error_count    = 0;
      mismatch_count = 0;
      put_header(0, LastIdx, 1'b0, '0);
      put_header(LastIdx, 0, 1'b1, '0);
    endfunction

    function void put_header(int idx, int nxt, bit busy, logic [OwnerInW-1:0] tag);
      link[idx]   = nxt[AddrW-1:0];
      in_use[idx] = busy;
      tag_of[idx] = tag;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_list.push_back(idx);
      end
    endfunction

    function void clear_header(int idx);
      in_use[idx] = 1'b0;
      tag_of[idx] = '0;
    endfunction

    // First-fit search from the base, merging idle neighbours on the way, with at
    // most two passes round the chain.
    function bit predict_alloc(int words, logic [OwnerInW-1:0] tag, output int addr);
      int nw;
      int p;
      int q;
      int passes;
      int steps;
      int split;
      nw     = words + 1;
      p      = 0;
      q      = 0;
      passes = 0;
      steps  = 0;
      addr   = 0;
      while (1) begin
        if (!in_use[p]) begin
          while (1) begin
            q = link[p];
            if (in_use[q]) break;
            steps++;
            if (steps > WalkLimit) return 1'b0;
            link[p] = link[q];
          end
          if (q >= p + nw) break;
        end
        steps++;
        if (steps > WalkLimit) return 1'b0;
        q = p;
        p = link[p];
        if (p <= q) begin
          if (p != 0) return 1'b0;
          passes++;
          if (passes > 1) return 1'b0;
        end
      end
      split = p + nw;
      if (q > split) put_header(split, link[p], 1'b0, '0);
      put_header(p, split, 1'b1, tag);
      addr = p + 1;
      return 1'b1;
    endfunction

    function void release_owner_blocks(logic [OwnerInW-1:0] tag);
      int p;
      int r;
      if (tag_of[0] == tag) clear_header(0);
      p = 0;
      while (1) begin
        r = link[p];
        if (r <= p) break;
        if (tag_of[r] == tag && r != LastIdx) clear_header(r);
        p = r;
      end
    endfunction

    function void note_request(logic [ActionW-1:0] act, logic [ReqWordsW-1:0] words,
                               logic [OwnerInW-1:0] tag, logic [AddrW-1:0] baddr);
      result_t res;
      int      addr;
      res.ok      = 1'b0;
      res.address = '0;
      case (act)
        ActAlloc: begin
          if (predict_alloc(int'(words), tag, addr)) begin
            res.ok      = 1'b1;
            res.address = addr[AddrW-1:0];
          end
        end
        ActFree: begin
          if (baddr != '0) clear_header(int'(baddr) - 1);
          res.ok = 1'b1;
        end
        ActFreeAll: begin
          release_owner_blocks(tag);
          res.ok = 1'b1;
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic ok, logic [AddrW-1:0] address);
      result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result ok=%0b address=%0d", $realtime, ok, address);
        return;
      end
      want = pending_results.pop_front();
      if (want.ok !== ok || want.address !== address) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch: expected ok=%0b address=%0d, got ok=%0b address=%0d",
                   $realtime, want.ok, want.address, ok, address);
      end
    endfunction

    // Data index of a random busy block on the chain, or zero when there is none.
    function int random_busy_block();
      int found[$];
      int p;
      p = 0;
      do begin
        if (in_use[p] && p != LastIdx) found.push_back(p + 1);
        p = link[p];
      end while (p != 0);
      if (found.size() == 0) return 0;
      return found[$urandom_range(found.size() - 1)];
    endfunction

    // Data index above any header that has ever been written, live or stale. Freeing
    // through it never touches a word whose contents are undefined.
    function int random_written_header();
      int idx;
      do idx = written_list[$urandom_range(written_list.size() - 1)];
      while (idx == LastIdx);
      return idx + 1;
    endfunction

    function int owner_at(int baddr);
      if (baddr == 0) return 0;
      return int'(tag_of[baddr - 1]);
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [ActionW-1:0]   action_i        = '0;
  logic [ReqWordsW-1:0] request_words_i = '0;
  logic [OwnerInW-1:0]  owner_i         = '0;
  logic [AddrW-1:0]     block_address_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic                 ok_o;
  logic [AddrW-1:0]     address_o;

  arena_scoreboard sb;
  int              items_sent   = 0;
  int              results_seen = 0;

  first_fit_arena_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .request_words_i (request_words_i),
    .owner_i         (owner_i),
    .block_address_i (block_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ok_o            (ok_o),
    .address_o       (address_o)
  );

  always #10 clk_i = ~clk_i;

  // A stretch of items in the middle of the random part runs with neither side
  // idling, so that back-to-back handshakes are seen as well.
  function automatic bit calm_window(int count);
    return count >= 380 && count < 530;
  endfunction

  // Allocation sizes are mostly small so that the chain grows long and the walks
  // merge often; now and then a large request tests the failure path.
  function automatic int pick_words();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(31);
    if (r < 95) return $urandom_range(255, 32);
    return $urandom_range(1022, 256);
  endfunction

  // Owners come mostly from a small pool, so that freeing all of one owner hits.
  function automatic int pick_owner();
    if ($urandom_range(99) < 70) return $urandom_range(7);
    return $urandom_range(255);
  endfunction

  // Offers one item from a falling edge and holds it until it is taken. The caller
  // is always at a falling edge, and the task returns at the next one, so valid is
  // only ever assigned once in a time step.
  task automatic issue(logic [ActionW-1:0] act, int words, int tag, int baddr);
    while (!calm_window(items_sent) && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    action_i        <= act;
    request_words_i <= words[ReqWordsW-1:0];
    owner_i         <= tag[OwnerInW-1:0];
    block_address_i <= baddr[AddrW-1:0];
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(act, words[ReqWordsW-1:0], tag[OwnerInW-1:0], baddr[AddrW-1:0]);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stimulus: a directed opening that walks the arena through its corner cases,
  // followed by a long random mix of allocations and frees.
  initial begin
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The largest request fills the whole arena; after that nothing else fits.
    issue(ActAlloc, 1022, 255, 1);
    issue(ActAlloc, 0, 0, 1);
    issue(ActUnknown, $urandom_range(1022), $urandom_range(255), 0);
    // A free at data index zero is ignored but still answered.
    issue(ActFree, 0, 0, 0);
    issue(ActFree, 0, 0, 1);
    // One word short of the maximum leaves a split header just below the sentinel.
    issue(ActAlloc, 1021, 8'h5A, 1);
    issue(ActFree, 0, 0, 1023);
    issue(ActFree, 0, 0, 1);
    // Now the base has to merge with the idle split header to satisfy this.
    issue(ActAlloc, 1022, 0, 1);
    issue(ActFreeAll, 0, 0, 1);
    issue(ActAlloc, 3, 1, 1);
    issue(ActAlloc, 5, 2, 1);
    issue(ActAlloc, 0, 1, 1);
    issue(ActAlloc, 7, 3, 1);
    issue(ActFreeAll, 0, 1, 1);
    // First fit should land in the hole that freeing owner 1 opened.
    issue(ActAlloc, 2, 4, 1);
    issue(ActFree, 0, 0, sb.random_busy_block());
    // Freeing a header that is idle or no longer on the chain goes unchecked.
    issue(ActFree, 0, 0, sb.random_written_header());
    issue(ActFreeAll, 0, 8'h80, 1);
    issue(ActAlloc, 1022, 9, 1);
    issue(ActUnknown, 1022, 255, 1023);
    issue(ActAlloc, 0, 255, 1);
    issue(ActFreeAll, 0, 0, 1);

    for (int n = 0; n < RandomItems; n++) begin
      int r;
      int target;
      r = $urandom_range(99);
      if (r < 52) begin
        issue(ActAlloc, pick_words(), pick_owner(), $urandom_range(1023, 1));
      end else if (r < 82) begin
        issue(ActFree, $urandom_range(1022), $urandom_range(255), sb.random_busy_block());
      end else if (r < 88) begin
        issue(ActFree, $urandom_range(1022), $urandom_range(255), sb.random_written_header());
      end else if (r < 90) begin
        issue(ActFree, $urandom_range(1022), $urandom_range(255), 0);
      end else if (r < 97) begin
        target = sb.random_busy_block();
        if (target != 0 && $urandom_range(1) == 1)
          issue(ActFreeAll, $urandom_range(1022), sb.owner_at(target), $urandom_range(1023, 1));
        else
          issue(ActFreeAll, $urandom_range(1022), pick_owner(), $urandom_range(1023, 1));
      end else begin
        issue(ActUnknown, $urandom_range(1022), $urandom_range(255), $urandom_range(1023));
      end
    end
    in_valid_i <= 1'b0;

    // Every item gives exactly one result, so once the queue is empty the block is
    // idle; a short tail catches any result that should not be there.
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side. Ready is set at the falling edge and the handshake is judged at the
  // rising one. Once, after a couple of hundred results, the receiver holds off for
  // a long stretch so that the output register and the working item back up and the
  // block has to stall its input while items keep being offered.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        for (int c = 0; c < 400; c++) @(negedge clk_i);
      end
      out_ready_i <= calm_window(results_seen) || ($urandom_range(99) >= 11);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(ok_o, address_o);
        results_seen++;
      end
    end
  end

  // Overall limit, well beyond a run in which every allocation walks a long chain
  // twice and every result waits out the longest stall.
  initial begin
    #300ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
